/* sv/msdb_pkg.sv */
package msdb_pkg;

   // Largest frame and sample grid that the stores are sized for.
   localparam int MAX_PIXELS_X  = 64;
   localparam int MAX_PIXELS_Y  = 64;
   localparam int MAX_SAMPLES_X = 4;
   localparam int MAX_SAMPLES_Y = 4;

   // Store geometry: fixed row strides so entries keep their place.
   localparam int GRID_W       = MAX_PIXELS_X * MAX_SAMPLES_X;
   localparam int GRID_H       = MAX_PIXELS_Y * MAX_SAMPLES_Y;
   localparam int SAMPLE_COUNT = GRID_W * GRID_H;
   localparam int PIXEL_COUNT  = MAX_PIXELS_X * MAX_PIXELS_Y;
   localparam int SAMPLE_AW    = $clog2(SAMPLE_COUNT);
   localparam int PIXEL_AW     = $clog2(PIXEL_COUNT);

   // Field and register widths.
   localparam int DEPTH_W    = 24;
   localparam int COORD_W    = 8;
   localparam int OP_W       = 2;
   localparam int PIX_REG_W  = 7;
   localparam int SAMP_REG_W = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam int GRID_LIM_W = PIX_REG_W + SAMP_REG_W;
   localparam int BASE_W     = COORD_W + SAMP_REG_W;

   // The all-ones depth code stands for infinity.
   localparam logic [DEPTH_W-1:0] DEPTH_INFINITY = '1;

   // Register values after reset.
   localparam logic [PIX_REG_W-1:0]  PIXELS_WIDE_RESET = PIX_REG_W'(64);
   localparam logic [PIX_REG_W-1:0]  PIXELS_HIGH_RESET = PIX_REG_W'(64);
   localparam logic [SAMP_REG_W-1:0] SAMPLES_X_RESET   = SAMP_REG_W'(1);
   localparam logic [SAMP_REG_W-1:0] SAMPLES_Y_RESET   = SAMP_REG_W'(1);

   // Request operation codes.
   typedef enum logic [OP_W-1:0] {
      OP_TEST    = 2'd0,
      OP_RESOLVE = 2'd1,
      OP_READ    = 2'd2
   } op_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PIXELS_WIDE = 2'd0,
      CSR_PIXELS_HIGH = 2'd1,
      CSR_SAMPLES_X   = 2'd2,
      CSR_SAMPLES_Y   = 2'd3
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TEST_CMP,
      ST_PIX_DATA,
      ST_RES_RD,
      ST_RES_LAST,
      ST_FINISH
   } state_type;

endpackage

/* sv/msdb_ram.sv */
module msdb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/multisample_depth_buffer_top.sv */
// Multisample depth buffer.
// Requests enter on the req_ channel (valid/stall) and carry an operation,
// a coordinate and a depth. Test-and-set compares the depth with one stored
// sample and replaces it when strictly nearer; resolve takes the minimum
// over one pixel's samples, stores and returns it; read returns a stored
// resolved depth. Every request gives exactly one response on the rsp_
// channel. Grid size is set through the csr_ write port while idle; the
// user is bound to that, as the block itself does not enforce it.
// A test-and-set request passes through ST_TEST_CMP, a read through
// ST_PIX_DATA, a resolve through ST_RES_RD and ST_RES_LAST, and a bad
// coordinate or unused code goes straight to ST_FINISH, where the response
// is loaded into the output register once it is free. The next request is
// taken in the cycle after the response is loaded; the sample memory has a
// single read port, which the resolve walks one sample per cycle.
// After reset the block clears both memories to infinity, one sample entry
// per cycle, and holds req_stall high meanwhile; configuration writes are
// taken as ever.
// The response sits in an output register, so one request can be taken
// and worked on while rsp_stall holds an earlier response.
module multisample_depth_buffer_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [msdb_pkg::OP_W-1:0]         req_operation,
   input  logic [msdb_pkg::COORD_W-1:0]      req_coord_x,
   input  logic [msdb_pkg::COORD_W-1:0]      req_coord_y,
   input  logic [msdb_pkg::DEPTH_W-1:0]      req_depth,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_passed,
   output logic [msdb_pkg::DEPTH_W-1:0]      rsp_depth_out,
   output logic                              rsp_bad_coordinate,
   input  logic                              csr_wr_en,
   input  logic [msdb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [msdb_pkg::CSR_DATA_W-1:0]   csr_data
);

   import msdb_pkg::*;

   state_type state_ff, state_in;

   logic [PIX_REG_W-1:0]  pixels_wide_ff, pixels_wide_in;
   logic [PIX_REG_W-1:0]  pixels_high_ff, pixels_high_in;
   logic [SAMP_REG_W-1:0] samples_x_ff, samples_x_in;
   logic [SAMP_REG_W-1:0] samples_y_ff, samples_y_in;

   logic [PIX_REG_W-1:0]  pw, ph;
   logic [SAMP_REG_W-1:0] sxn, syn;
   logic [GRID_LIM_W-1:0] gw, gh;

   logic [SAMPLE_AW-1:0] clr_ff, clr_in;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;
   logic [PIXEL_AW-1:0]  pix_addr_ff, pix_addr_in;
   logic [BASE_W-1:0]    base_x_ff, base_x_in, base_y_ff, base_y_in;
   logic [SAMP_REG_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [DEPTH_W-1:0]   min_ff, min_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [SAMPLE_AW-1:0] test_addr_ff, test_addr_in;

   logic                 res_passed_ff, res_passed_in;
   logic [DEPTH_W-1:0]   res_depth_ff, res_depth_in;
   logic                 res_bad_ff, res_bad_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_passed_ff, rsp_passed_in;
   logic [DEPTH_W-1:0]   rsp_depth_ff, rsp_depth_in;
   logic                 rsp_bad_ff, rsp_bad_in;

   logic                 req_accept, req_bad, rsp_free;
   logic                 last_i, last_j;
   logic [BASE_W-1:0]    gx, gy;
   logic [SAMPLE_AW-1:0] test_addr, res_addr;
   logic [PIXEL_AW-1:0]  req_pix_addr;
   logic [DEPTH_W-1:0]   res_min;

   logic                 sample_wr_en;
   logic [SAMPLE_AW-1:0] sample_wr_addr, sample_rd_addr;
   logic [DEPTH_W-1:0]   sample_wr_data, sample_rd_data;
   logic                 pixel_wr_en;
   logic [PIXEL_AW-1:0]  pixel_wr_addr;
   logic [DEPTH_W-1:0]   pixel_wr_data, pixel_rd_data;

   // Saturated grid dimensions; a zero sample count acts as one.
   always_comb begin
      pw = (int'(pixels_wide_ff) > MAX_PIXELS_X) ? PIX_REG_W'(MAX_PIXELS_X) : pixels_wide_ff;
      ph = (int'(pixels_high_ff) > MAX_PIXELS_Y) ? PIX_REG_W'(MAX_PIXELS_Y) : pixels_high_ff;
      if (samples_x_ff == '0) begin
         sxn = SAMP_REG_W'(1);
      end else if (int'(samples_x_ff) > MAX_SAMPLES_X) begin
         sxn = SAMP_REG_W'(MAX_SAMPLES_X);
      end else begin
         sxn = samples_x_ff;
      end
      if (samples_y_ff == '0) begin
         syn = SAMP_REG_W'(1);
      end else if (int'(samples_y_ff) > MAX_SAMPLES_Y) begin
         syn = SAMP_REG_W'(MAX_SAMPLES_Y);
      end else begin
         syn = samples_y_ff;
      end
      gw = GRID_LIM_W'(pw) * GRID_LIM_W'(sxn);
      gh = GRID_LIM_W'(ph) * GRID_LIM_W'(syn);
   end

   // Handshake and coordinate check of the incoming request.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (req_operation)
         OP_TEST: begin
            req_bad = (GRID_LIM_W'(req_coord_x) >= gw) || (GRID_LIM_W'(req_coord_y) >= gh);
         end
         OP_RESOLVE, OP_READ: begin
            req_bad = (req_coord_x >= COORD_W'(pw)) || (req_coord_y >= COORD_W'(ph));
         end
         default: begin
            req_bad = 1'b0;
         end
      endcase
   end

   // Memory addresses for the request fields and for the resolve walk.
   assign test_addr    = SAMPLE_AW'(req_coord_y) * SAMPLE_AW'(GRID_W) + SAMPLE_AW'(req_coord_x);
   assign req_pix_addr = PIXEL_AW'(req_coord_y) * PIXEL_AW'(MAX_PIXELS_X)
                         + PIXEL_AW'(req_coord_x);
   assign gx           = base_x_ff + BASE_W'(i_ff);
   assign gy           = base_y_ff + BASE_W'(j_ff);
   assign res_addr     = SAMPLE_AW'(gy) * SAMPLE_AW'(GRID_W) + SAMPLE_AW'(gx);
   assign last_i       = (i_ff == sxn - SAMP_REG_W'(1));
   assign last_j       = (j_ff == syn - SAMP_REG_W'(1));

   // Running minimum including the sample that arrives this cycle.
   assign res_min = (rd_valid_ff && (sample_rd_data < min_ff)) ? sample_rd_data : min_ff;

   // The sample address of a test request is kept for its write back.
   assign test_addr_in = req_accept ? test_addr : test_addr_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == SAMPLE_AW'(SAMPLE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_bad) begin
                  state_in = ST_FINISH;
               end else begin
                  case (req_operation)
                     OP_TEST:    state_in = ST_TEST_CMP;
                     OP_RESOLVE: state_in = ST_RES_RD;
                     OP_READ:    state_in = ST_PIX_DATA;
                     default:    state_in = ST_FINISH;
                  endcase
               end
            end
         end
         ST_TEST_CMP: begin
            state_in = ST_FINISH;
         end
         ST_PIX_DATA: begin
            state_in = ST_FINISH;
         end
         ST_RES_RD: begin
            if (last_i && last_j) begin
               state_in = ST_RES_LAST;
            end
         end
         ST_RES_LAST: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      clr_in         = clr_ff;
      depth_in       = depth_ff;
      pix_addr_in    = pix_addr_ff;
      base_x_in      = base_x_ff;
      base_y_in      = base_y_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      min_in         = min_ff;
      rd_valid_in    = (state_ff == ST_RES_RD);
      res_passed_in  = res_passed_ff;
      res_depth_in   = res_depth_ff;
      res_bad_in     = res_bad_ff;
      sample_wr_en   = 1'b0;
      sample_wr_addr = clr_ff;
      sample_wr_data = DEPTH_INFINITY;
      sample_rd_addr = test_addr;
      pixel_wr_en    = 1'b0;
      pixel_wr_addr  = pix_addr_ff;
      pixel_wr_data  = res_min;
      case (state_ff)
         ST_CLEAR: begin
            clr_in        = clr_ff + SAMPLE_AW'(1);
            sample_wr_en  = 1'b1;
            pixel_wr_en   = ({1'b0, clr_ff} < (SAMPLE_AW + 1)'(PIXEL_COUNT));
            pixel_wr_addr = PIXEL_AW'(clr_ff);
            pixel_wr_data = DEPTH_INFINITY;
         end
         ST_IDLE: begin
            if (req_accept) begin
               depth_in      = req_depth;
               pix_addr_in   = req_pix_addr;
               base_x_in     = BASE_W'(req_coord_x) * BASE_W'(sxn);
               base_y_in     = BASE_W'(req_coord_y) * BASE_W'(syn);
               i_in          = '0;
               j_in          = '0;
               min_in        = DEPTH_INFINITY;
               res_passed_in = 1'b0;
               res_depth_in  = '0;
               res_bad_in    = req_bad;
            end
         end
         ST_TEST_CMP: begin
            // The test write goes back to the sample that was read at accept.
            if (depth_ff < sample_rd_data) begin
               sample_wr_en   = 1'b1;
               sample_wr_addr = test_addr_ff;
               sample_wr_data = depth_ff;
               res_passed_in  = 1'b1;
            end
         end
         ST_PIX_DATA: begin
            res_depth_in = pixel_rd_data;
         end
         ST_RES_RD: begin
            sample_rd_addr = res_addr;
            min_in         = res_min;
            if (last_i) begin
               i_in = '0;
               j_in = j_ff + SAMP_REG_W'(1);
            end else begin
               i_in = i_ff + SAMP_REG_W'(1);
            end
         end
         ST_RES_LAST: begin
            min_in       = res_min;
            pixel_wr_en  = 1'b1;
            res_depth_in = res_min;
         end
         default: begin
         end
      endcase
   end

   // Output register and configuration writes.
   always_comb begin
      rsp_passed_in = rsp_passed_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_bad_in    = rsp_bad_ff;
      if ((state_ff == ST_FINISH) && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_passed_in = res_passed_ff;
         rsp_depth_in  = res_depth_ff;
         rsp_bad_in    = res_bad_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      pixels_wide_in = pixels_wide_ff;
      pixels_high_in = pixels_high_ff;
      samples_x_in   = samples_x_ff;
      samples_y_in   = samples_y_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_PIXELS_WIDE: pixels_wide_in = csr_data[PIX_REG_W-1:0];
            CSR_PIXELS_HIGH: pixels_high_in = csr_data[PIX_REG_W-1:0];
            CSR_SAMPLES_X:   samples_x_in   = csr_data[SAMP_REG_W-1:0];
            CSR_SAMPLES_Y:   samples_y_in   = csr_data[SAMP_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         pixels_wide_ff <= PIXELS_WIDE_RESET;
         pixels_high_ff <= PIXELS_HIGH_RESET;
         samples_x_ff   <= SAMPLES_X_RESET;
         samples_y_ff   <= SAMPLES_Y_RESET;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         rd_valid_ff    <= rd_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         pixels_wide_ff <= pixels_wide_in;
         pixels_high_ff <= pixels_high_in;
         samples_x_ff   <= samples_x_in;
         samples_y_ff   <= samples_y_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      depth_ff      <= depth_in;
      pix_addr_ff   <= pix_addr_in;
      test_addr_ff  <= test_addr_in;
      base_x_ff     <= base_x_in;
      base_y_ff     <= base_y_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      min_ff        <= min_in;
      res_passed_ff <= res_passed_in;
      res_depth_ff  <= res_depth_in;
      res_bad_ff    <= res_bad_in;
      rsp_passed_ff <= rsp_passed_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_bad_ff    <= rsp_bad_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_passed         = rsp_passed_ff;
   assign rsp_depth_out      = rsp_depth_ff;
   assign rsp_bad_coordinate = rsp_bad_ff;

   // Per-sample depth store.
   msdb_ram #(
      .WIDTH (DEPTH_W),
      .DEPTH (SAMPLE_COUNT)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (sample_wr_en),
      .wr_addr (sample_wr_addr),
      .wr_data (sample_wr_data),
      .rd_addr (sample_rd_addr),
      .rd_data (sample_rd_data)
   );

   // Per-pixel resolved depth store.
   msdb_ram #(
      .WIDTH (DEPTH_W),
      .DEPTH (PIXEL_COUNT)
   ) u_pixel_ram (
      .clock   (clock),
      .wr_en   (pixel_wr_en),
      .wr_addr (pixel_wr_addr),
      .wr_data (pixel_wr_data),
      .rd_addr (req_pix_addr),
      .rd_data (pixel_rd_data)
   );

endmodule
